FILE: hdl/oaht_pkg.sv
`default_nettype none

package oaht_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_VALUE_BITS  = 32;

  localparam int unsigned KEY_W       = 31;
  localparam int unsigned IN_VALUE_W  = 32;
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned MARK_W      = 2;

  localparam int unsigned REM_BITS_PER_CYCLE = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DIVISOR = 2'd2;

  localparam logic              RST_PROBE_MODE   = 1'b0;
  localparam logic [SIZE_W-1:0] RST_TABLE_SIZE   = 9'd256;
  localparam logic [SIZE_W-1:0] RST_STEP_DIVISOR = 9'd251;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_DOUBLE = 1'b1;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_ERASE  = 1'b1;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_ERASED   = 2'd2,
    ST_MISSING  = 2'd3
  } status_e;

  typedef struct packed {
    logic                  action;
    logic [KEY_W-1:0]      key;
    logic [IN_VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/oaht_ram.sv
`default_nettype none

module oaht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/oaht_rem.sv
`default_nettype none

module oaht_rem #(
  parameter int unsigned DIVIDEND_W = 31,
  parameter int unsigned DIVISOR_W  = 9
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic      [DIVISOR_W-1:0]  rem_o
);

  localparam int unsigned BPC   = oaht_pkg::REM_BITS_PER_CYCLE;
  localparam int unsigned STEPS = (DIVIDEND_W + BPC - 1) / BPC;
  localparam int unsigned PAD_W = STEPS * BPC;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0]     shift_q;
  logic [DIVISOR_W-1:0] div_q;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;

  always_comb begin
    logic [DIVISOR_W:0] t;
    rem_d = rem_q;
    for (int b = 0; b < int'(BPC); b++) begin
      t = {rem_d, shift_q[PAD_W-1-b]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_d = t[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= PAD_W'(dividend_i);
      div_q   <= divisor_i;
      rem_q   <= '0;
    end else if (cnt_q != '0) begin
      shift_q <= shift_q << BPC;
      rem_q   <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: hdl/open_addressing_hash_table.sv
`default_nettype none

// Open-addressing hash table with tombstones: each request inserts or erases one key, and
// exactly one result follows on rsp_o, marked by a one-cycle done_o strobe that the
// receiver cannot stall. After reset the block clears the slot marks with busy high;
// configuration writes are accepted at any time but belong to idle periods. A request
// first computes two key remainders, four bits a cycle, then reduces the probe step
// modulo the table size; every probe is then one read of the slot memory followed by a
// check and possible write-back. The number of probes is data dependent, up to the
// table size.
module open_addressing_hash_table #(
  parameter int unsigned TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = oaht_pkg::DEF_VALUE_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire oaht_pkg::req_t                   req_i,
  output logic                                  done_o,
  output oaht_pkg::rsp_t                        rsp_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [oaht_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [oaht_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SZ_W   = (oaht_pkg::SIZE_W > CNT_W) ? oaht_pkg::SIZE_W : CNT_W;
  localparam int unsigned KEY_W  = oaht_pkg::KEY_W;
  localparam int unsigned MARK_W = oaht_pkg::MARK_W;
  localparam int unsigned WORD_W = MARK_W + KEY_W + VALUE_BITS;
  localparam int unsigned Q_W    = oaht_pkg::SIZE_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_KMOD  = 6'b000100,
    S_SMOD  = 6'b001000,
    S_READ  = 6'b010000,
    S_CHECK = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic                          mode_q;
  logic [Q_W-1:0]                size_q;
  logic [Q_W-1:0]                divisor_q;

  oaht_pkg::req_t                req_q;
  logic                          mode_item_q;
  logic [CNT_W-1:0]              n_q;
  logic [CNT_W-1:0]              n_eff;
  logic [Q_W-1:0]                q_eff;
  logic [Q_W-1:0]                q_q;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [IDX_W-1:0]              clr_q, clr_d;

  logic                          accept;
  logic                          kn_done, kq_done, sn_done;
  logic [CNT_W-1:0]              kn_rem, sn_rem;
  logic [Q_W-1:0]                kq_rem;
  logic [Q_W-1:0]                step;

  logic [IDX_W-1:0]              ram_addr;
  logic                          ram_we;
  logic [WORD_W-1:0]             ram_wdata, ram_rdata;
  logic [MARK_W-1:0]             rd_mark;
  logic [KEY_W-1:0]              rd_key;
  logic [VALUE_BITS-1:0]         rd_value;

  logic                          hit_ins, hit_er, miss_empty, last_probe, finish;
  logic [IDX_W:0]                idx_sum;
  logic                          done_q, done_d;
  oaht_pkg::rsp_t                rsp_q, rsp_d;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= oaht_pkg::RST_PROBE_MODE;
      size_q    <= oaht_pkg::RST_TABLE_SIZE;
      divisor_q <= oaht_pkg::RST_STEP_DIVISOR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        oaht_pkg::CFG_PROBE_MODE:   mode_q    <= cfg_data_i[0];
        oaht_pkg::CFG_TABLE_SIZE:   size_q    <= cfg_data_i;
        oaht_pkg::CFG_STEP_DIVISOR: divisor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [SZ_W-1:0] ts;
    ts = SZ_W'(size_q);
    if (ts == '0) begin
      n_eff = CNT_W'(1);
    end else if (ts > SZ_W'(TABLE_DEPTH)) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(ts);
    end
    q_eff = (divisor_q == '0) ? Q_W'(1) : divisor_q;
  end

  oaht_rem #(
    .DIVIDEND_W (KEY_W),
    .DIVISOR_W  (CNT_W)
  ) u_rem_key_n (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (req_i.key),
    .divisor_i  (n_eff),
    .done_o     (kn_done),
    .rem_o      (kn_rem)
  );

  oaht_rem #(
    .DIVIDEND_W (KEY_W),
    .DIVISOR_W  (Q_W)
  ) u_rem_key_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (req_i.key),
    .divisor_i  (q_eff),
    .done_o     (kq_done),
    .rem_o      (kq_rem)
  );

  assign step = (mode_item_q == oaht_pkg::MODE_DOUBLE) ? (q_q - kq_rem) : Q_W'(1);

  oaht_rem #(
    .DIVIDEND_W (Q_W),
    .DIVISOR_W  (CNT_W)
  ) u_rem_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_KMOD && kn_done && kq_done),
    .dividend_i (step),
    .divisor_i  (n_q),
    .done_o     (sn_done),
    .rem_o      (sn_rem)
  );

  assign rd_mark  = ram_rdata[WORD_W-1 -: MARK_W];
  assign rd_key   = ram_rdata[VALUE_BITS +: KEY_W];
  assign rd_value = ram_rdata[VALUE_BITS-1:0];

  assign hit_ins    = (req_q.action == oaht_pkg::ACT_INSERT) &&
                      (rd_mark != oaht_pkg::MARK_USED);
  assign miss_empty = (req_q.action == oaht_pkg::ACT_ERASE) &&
                      (rd_mark == oaht_pkg::MARK_EMPTY);
  assign hit_er     = (req_q.action == oaht_pkg::ACT_ERASE) &&
                      (rd_mark == oaht_pkg::MARK_USED) && (rd_key == req_q.key);
  assign last_probe = (count_q + CNT_W'(1)) == n_q;
  assign finish     = hit_ins || miss_empty || hit_er || last_probe;
  assign idx_sum    = {1'b0, idx_q} + {1'b0, IDX_W'(sn_rem)};

  always_comb begin
    ram_addr  = idx_q;
    ram_we    = 1'b0;
    ram_wdata = {oaht_pkg::MARK_USED, req_q.key, VALUE_BITS'(req_q.value)};
    if (state_q == S_CLEAR) begin
      ram_addr  = clr_q;
      ram_we    = 1'b1;
      ram_wdata = {oaht_pkg::MARK_EMPTY, {(KEY_W + VALUE_BITS){1'b0}}};
    end else if (state_q == S_CHECK) begin
      if (hit_ins) begin
        ram_we = 1'b1;
      end else if (hit_er) begin
        ram_we    = 1'b1;
        ram_wdata = {oaht_pkg::MARK_GONE, rd_key, rd_value};
      end
    end
  end

  oaht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    clr_d   = clr_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_KMOD;
        end
      end
      S_KMOD: begin
        if (kn_done && kq_done) begin
          idx_d   = IDX_W'(kn_rem);
          count_d = '0;
          state_d = S_SMOD;
        end
      end
      S_SMOD: begin
        if (sn_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (finish) begin
          state_d          = S_IDLE;
          done_d           = 1'b1;
          rsp_d.slot_index = '0;
          if (hit_ins) begin
            rsp_d.status     = oaht_pkg::ST_INSERTED;
            rsp_d.slot_index = oaht_pkg::SLOT_W'(idx_q);
          end else if (hit_er) begin
            rsp_d.status     = oaht_pkg::ST_ERASED;
            rsp_d.slot_index = oaht_pkg::SLOT_W'(idx_q);
          end else if (req_q.action == oaht_pkg::ACT_INSERT) begin
            rsp_d.status = oaht_pkg::ST_FULL;
          end else begin
            rsp_d.status = oaht_pkg::ST_MISSING;
          end
        end else begin
          count_d = count_q + CNT_W'(1);
          if (idx_sum >= (IDX_W + 1)'(n_q)) begin
            idx_d = IDX_W'(idx_sum - (IDX_W + 1)'(n_q));
          end else begin
            idx_d = IDX_W'(idx_sum);
          end
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= req_i;
      mode_item_q <= mode_q;
      n_q         <= n_eff;
      q_q         <= q_eff;
    end
    idx_q   <= idx_d;
    count_q <= count_d;
    rsp_q   <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

FILE: test/open_addressing_hash_table_tb.sv
`timescale 1ns / 100ps

module open_addressing_hash_table_tb;

  localparam int unsigned SLOTS = oaht_pkg::DEF_TABLE_DEPTH;
  localparam int unsigned KEY_W = oaht_pkg::KEY_W;
  localparam int unsigned IN_VALUE_W = oaht_pkg::IN_VALUE_W;
  localparam int unsigned SIZE_W = oaht_pkg::SIZE_W;
  localparam int unsigned SLOT_W = oaht_pkg::SLOT_W;
  localparam int unsigned CFG_IDX_W = oaht_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = oaht_pkg::CFG_DATA_W;
  localparam int unsigned REQUESTS_PER_SETTING = 100;
  localparam int unsigned RANDOM_SETTINGS = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start_q = 1'b0;
  logic busy;
  oaht_pkg::req_t req_q = '0;
  logic done;
  oaht_pkg::rsp_t rsp;
  logic cfg_valid_q = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index_q = oaht_pkg::CFG_PROBE_MODE;
  logic [CFG_DATA_W-1:0] cfg_data_q = '0;

  oaht_pkg::mark_e slot_mark [SLOTS];
  logic [KEY_W-1:0] slot_key [SLOTS];
  logic mode_cfg;
  logic [SIZE_W-1:0] size_cfg;
  logic [SIZE_W-1:0] divisor_cfg;

  oaht_pkg::req_t pending_requests[$];
  oaht_pkg::rsp_t table_outcomes[$];
  int unsigned key_pool[$];
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned error_count = 0;
  int unsigned insert_count = 0;
  int unsigned erase_count = 0;
  int unsigned setting_count = 1;
  int unsigned status_count [4] = '{0, 0, 0, 0};

  open_addressing_hash_table u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start_q),
    .busy        (busy),
    .req_i       (req_q),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index_q),
    .cfg_data_i  (cfg_data_q)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned effective_size();
    int unsigned n;
    n = 32'(size_cfg);
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // Walks the probe sequence on the shadow table and applies the request to it.
  function automatic oaht_pkg::rsp_t apply_table_request(input oaht_pkg::req_t r);
    int unsigned n;
    int unsigned q;
    int unsigned step;
    int unsigned slot;
    int unsigned probe;
    logic found;
    oaht_pkg::rsp_t res;
    n = effective_size();
    if (mode_cfg == oaht_pkg::MODE_LINEAR) begin
      step = 1;
    end else begin
      q = (divisor_cfg == '0) ? 32'd1 : 32'(divisor_cfg);
      step = q - (32'(r.key) % q);
    end
    slot = 32'(r.key) % n;
    res.status = (r.action == oaht_pkg::ACT_INSERT) ? oaht_pkg::ST_FULL : oaht_pkg::ST_MISSING;
    res.slot_index = '0;
    found = 1'b0;
    for (probe = 0; probe < n && !found; probe++) begin
      if (r.action == oaht_pkg::ACT_INSERT) begin
        if (slot_mark[slot] != oaht_pkg::MARK_USED) begin
          slot_mark[slot] = oaht_pkg::MARK_USED;
          slot_key[slot] = r.key;
          res.status = oaht_pkg::ST_INSERTED;
          res.slot_index = slot[SLOT_W-1:0];
          found = 1'b1;
        end
      end else if (slot_mark[slot] == oaht_pkg::MARK_EMPTY) begin
        found = 1'b1;
      end else if (slot_mark[slot] == oaht_pkg::MARK_USED && slot_key[slot] == r.key) begin
        slot_mark[slot] = oaht_pkg::MARK_GONE;
        res.status = oaht_pkg::ST_ERASED;
        res.slot_index = slot[SLOT_W-1:0];
        found = 1'b1;
      end
      slot = (slot + step) % n;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic queue_request(input logic action, input logic [KEY_W-1:0] key,
                               input logic [IN_VALUE_W-1:0] value);
    oaht_pkg::req_t r;
    r.action = action;
    r.key = key;
    r.value = value;
    pending_requests.push_back(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || start_q || busy || table_outcomes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic mode, input logic [SIZE_W-1:0] size,
                                input logic [SIZE_W-1:0] divisor);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= oaht_pkg::CFG_PROBE_MODE;
    cfg_data_q <= {{(CFG_DATA_W-1){1'b0}}, mode};
    do @(posedge clk); while (!cfg_ready);
    mode_cfg = mode;
    cfg_index_q <= oaht_pkg::CFG_TABLE_SIZE;
    cfg_data_q <= size;
    do @(posedge clk); while (!cfg_ready);
    size_cfg = size;
    cfg_index_q <= oaht_pkg::CFG_STEP_DIVISOR;
    cfg_data_q <= divisor;
    do @(posedge clk); while (!cfg_ready);
    divisor_cfg = divisor;
    cfg_valid_q <= 1'b0;
    setting_count++;
  endtask

  // Most erases target keys inserted earlier, so tombstones and probe chains build up.
  task automatic queue_random(input int unsigned count);
    int unsigned n;
    int unsigned pick;
    int unsigned at;
    int unsigned k;
    oaht_pkg::req_t r;
    n = effective_size();
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      r.value = $urandom;
      if (pick < 50) begin
        r.action = oaht_pkg::ACT_INSERT;
        if (pick < 15 && key_pool.size() != 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (pick < 25) k = $urandom & 32'h7FFF_FFFF;
        else k = $urandom_range(0, 4 * n + 7);
        key_pool.push_back(k);
        if (key_pool.size() > 48) key_pool.delete(0);
      end else if (pick < 90 && key_pool.size() != 0) begin
        r.action = oaht_pkg::ACT_ERASE;
        at = $urandom_range(0, key_pool.size() - 1);
        k = key_pool[at];
        key_pool.delete(at);
      end else begin
        r.action = ($urandom_range(0, 1) == 0) ? oaht_pkg::ACT_INSERT : oaht_pkg::ACT_ERASE;
        if (pick[0]) k = $urandom & 32'h7FFF_FFFF;
        else k = $urandom_range(0, 4 * n + 7);
      end
      r.key = k[KEY_W-1:0];
      pending_requests.push_back(r);
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start_q <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (start_q && !busy) begin
        table_outcomes.push_back(apply_table_request(req_q));
        status_count[table_outcomes[table_outcomes.size() - 1].status]++;
        if (req_q.action == oaht_pkg::ACT_INSERT) insert_count++;
        else erase_count++;
      end
      if (!start_q || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start_q <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req_q <= pending_requests.pop_front();
          start_q <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, ($urandom_range(0, 1) == 0) ? 6 : 40);
          end
        end else begin
          start_q <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    oaht_pkg::rsp_t want;
    if (rst_n && done) begin
      if (table_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding: status %0d slot %0d",
                                  rsp.status, rsp.slot_index));
      end else begin
        want = table_outcomes.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", rsp.status, want.status));
        if (rsp.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index %0d, wanted %0d", rsp.slot_index,
                                    want.slot_index));
      end
    end
  end

  initial begin : stimulus
    int unsigned setting;
    int unsigned pick;
    logic mode;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] divisor;
    foreach (slot_mark[i]) slot_mark[i] = oaht_pkg::MARK_EMPTY;
    mode_cfg = oaht_pkg::RST_PROBE_MODE;
    size_cfg = oaht_pkg::RST_TABLE_SIZE;
    divisor_cfg = oaht_pkg::RST_STEP_DIVISOR;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The reset settings: key and value extremes, tombstone reuse and a duplicate key.
    queue_request(oaht_pkg::ACT_INSERT, 31'd0, 32'd0);
    queue_request(oaht_pkg::ACT_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_request(oaht_pkg::ACT_ERASE, 31'd5, 32'hFFFF_FFFF);
    queue_request(oaht_pkg::ACT_ERASE, 31'd0, 32'd0);
    queue_request(oaht_pkg::ACT_ERASE, 31'd0, 32'd0);
    queue_request(oaht_pkg::ACT_INSERT, 31'd256, 32'hA5A5_5A5A);
    queue_request(oaht_pkg::ACT_INSERT, 31'd256, 32'h5A5A_A5A5);
    queue_request(oaht_pkg::ACT_ERASE, 31'd256, 32'd0);
    wait_idle();

    // A table size of zero behaves as one slot, and a zero divisor as one.
    apply_settings(oaht_pkg::MODE_DOUBLE, 9'd0, 9'd0);
    queue_request(oaht_pkg::ACT_INSERT, 31'd3, 32'h1234_5678);
    queue_request(oaht_pkg::ACT_INSERT, 31'd9, 32'h8765_4321);
    queue_request(oaht_pkg::ACT_ERASE, 31'd9, 32'd0);
    queue_request(oaht_pkg::ACT_ERASE, 31'd3, 32'd0);
    wait_idle();

    // A table size above the depth is clamped, with a divisor of 256.
    apply_settings(oaht_pkg::MODE_DOUBLE, 9'd511, 9'd256);
    queue_request(oaht_pkg::ACT_INSERT, 31'h7FFF_FFFF, 32'h0F0F_0F0F);
    queue_request(oaht_pkg::ACT_INSERT, 31'd1, 32'hF0F0_F0F0);
    queue_request(oaht_pkg::ACT_INSERT, 31'd257, 32'h3C3C_3C3C);
    queue_request(oaht_pkg::ACT_ERASE, 31'd257, 32'd0);
    wait_idle();

    // A step equal to the table size revisits the home slot until the probes run out.
    apply_settings(oaht_pkg::MODE_DOUBLE, 9'd4, 9'd4);
    queue_request(oaht_pkg::ACT_INSERT, 31'd0, 32'hCAFE_0001);
    queue_request(oaht_pkg::ACT_INSERT, 31'd4, 32'hCAFE_0002);
    queue_request(oaht_pkg::ACT_ERASE, 31'd8, 32'd0);
    queue_request(oaht_pkg::ACT_ERASE, 31'd0, 32'd0);

    for (setting = 0; setting < RANDOM_SETTINGS; setting++) begin
      wait_idle();
      case (setting)
        0: begin
          mode = oaht_pkg::MODE_DOUBLE;
          size = 9'd256;
          divisor = 9'd1;
        end
        1: begin
          mode = oaht_pkg::MODE_LINEAR;
          size = 9'd1;
          divisor = 9'd511;
        end
        2: begin
          mode = oaht_pkg::MODE_DOUBLE;
          size = 9'd300;
          divisor = 9'd0;
        end
        default: begin
          mode = ($urandom_range(0, 1) == 0) ? oaht_pkg::MODE_LINEAR : oaht_pkg::MODE_DOUBLE;
          pick = $urandom_range(0, 9);
          if (pick < 6) size = SIZE_W'($urandom_range(2, 16));
          else if (pick < 8) size = SIZE_W'($urandom_range(17, 64));
          else if (pick == 8) size = SIZE_W'($urandom_range(0, 1));
          else size = SIZE_W'($urandom_range(200, 511));
          pick = $urandom_range(0, 3);
          if (pick == 0) divisor = SIZE_W'($urandom_range(0, 511));
          else if (pick == 1) divisor = size;
          else if (pick == 2) divisor = SIZE_W'($urandom_range(1, 16));
          else divisor = {size[SIZE_W-2:0], 1'b0};
        end
      endcase
      apply_settings(mode, size, divisor);
      queue_random(REQUESTS_PER_SETTING);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Ran %0d inserts and %0d erases under %0d table settings.",
             insert_count, erase_count, setting_count);
    $display("Outcomes: %0d inserted, %0d full, %0d erased, %0d not found.",
             status_count[oaht_pkg::ST_INSERTED], status_count[oaht_pkg::ST_FULL],
             status_count[oaht_pkg::ST_ERASED], status_count[oaht_pkg::ST_MISSING]);
    if (error_count == 0 && table_outcomes.size() == 0) begin
      $display("open_addressing_hash_table_tb passed");
    end else begin
      $display("open_addressing_hash_table_tb failed");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("open_addressing_hash_table_tb failed");
    $finish;
  end

endmodule
